// ===== rtl/takf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// takf_pkg
// Shared types, constants and helpers of the tilt-angle Kalman filter.
// ----------------------------------------------------------------------------
package takf_pkg;

  localparam int NUM_AXES_DEF = 2;
  localparam int CFG_W        = 31;
  localparam int CFG_IDX_W    = 2;
  localparam int VAL_W        = 32;
  localparam int ACC_W        = 25;
  localparam int RATE_W       = 29;
  localparam int STATE_W      = 6 * VAL_W;

  localparam logic [CFG_W-1:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [CFG_W-1:0] RST_TIME     = 31'd107374182;
  localparam logic [CFG_W-1:0] RST_ANG_NOISE  = 31'd10737418;
  localparam logic [CFG_W-1:0] RST_BIAS_NOISE = 31'd322123;
  localparam logic [CFG_W-1:0] RST_MEAS_NOISE = 31'd10737418;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

  localparam logic [3:0] OP_ANG_PRED = 4'd0;
  localparam logic [3:0] OP_P00_A    = 4'd1;
  localparam logic [3:0] OP_P00_B    = 4'd2;
  localparam logic [3:0] OP_CROSS    = 4'd3;
  localparam logic [3:0] OP_P11_PRED = 4'd4;
  localparam logic [3:0] OP_ANG_UPD  = 4'd5;
  localparam logic [3:0] OP_BIAS_UPD = 4'd6;
  localparam logic [3:0] OP_P10_UPD  = 4'd7;
  localparam logic [3:0] OP_P00_UPD  = 4'd8;
  localparam logic [3:0] OP_P11_UPD  = 4'd9;
  localparam logic [3:0] OP_P01_UPD  = 4'd10;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] num;
    logic [VAL_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [39:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 40'sh00_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -40'sh00_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_reg(input logic [CFG_W-1:0] v);
    return (v > ONE_Q30) ? ONE_Q30 : v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/takf_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// takf_if
// Valid/ready channels for sample words and result words.
// ----------------------------------------------------------------------------
interface takf_in_if import takf_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic                     axis;
  logic signed [ACC_W-1:0]  accel_angle;
  logic signed [RATE_W-1:0] gyro_rate;
  modport source(output valid, axis, accel_angle, gyro_rate, input ready);
  modport sink(input valid, axis, accel_angle, gyro_rate, output ready);
endinterface

interface takf_out_if import takf_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    axis_out;
  logic signed [VAL_W-1:0] filtered_angle;
  logic signed [VAL_W-1:0] rate_bias;
  modport source(output valid, axis_out, filtered_angle, rate_bias, input ready);
  modport sink(input valid, axis_out, filtered_angle, rate_bias, output ready);
endinterface
`default_nettype wire

// ===== rtl/takf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// takf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module takf_ram #(
  parameter int W = 32,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/takf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// takf_div
// Serial gain divider: (num * 2^30) / den, truncated, saturated, one bit a cycle.
// ----------------------------------------------------------------------------
module takf_div import takf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [5:0]        cnt_r;
  logic              neg_r;
  logic [VAL_W-1:0]  den_r;
  logic [VAL_W-1:0]  rem_r;
  logic [61:0]       quo_r;
  logic [VAL_W-1:0]  mag;
  logic [VAL_W:0]    rem_sh;
  logic              fits;

  assign mag    = req.num[VAL_W-1] ? VAL_W'(-req.num) : req.num;
  assign rem_sh = {rem_r, quo_r[61]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        neg_r  <= req.num[VAL_W-1];
        den_r  <= req.den;
        rem_r  <= '0;
        quo_r  <= {mag, 30'b0};
      end else if (busy_r) begin
        rem_r <= fits ? VAL_W'(rem_sh - {1'b0, den_r}) : rem_sh[VAL_W-1:0];
        quo_r <= {quo_r[60:0], fits};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd61) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done_r;
    if (!neg_r) begin
      rsp.quo = (|quo_r[61:31]) ? 32'sh7FFF_FFFF : $signed(quo_r[31:0]);
    end else if ((|quo_r[61:32]) || (quo_r[31] && (|quo_r[30:0]))) begin
      rsp.quo = -32'sh8000_0000;
    end else begin
      rsp.quo = $signed(-quo_r[31:0]);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tilt_angle_kalman_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter
// Two-state angle/bias Kalman filter, one state set per axis in a RAM.
// ----------------------------------------------------------------------------
// One sample word at a time: an accepted word goes through read, predict
// products, gain setup, two serial gain divisions when p00 + mn is positive, update
// products and write-back before its result word is offered. Eleven products
// share one 34x34 multiplier. A new sample word is taken as soon as the
// previous one is written back, even while its result word waits.
module tilt_angle_kalman_filter import takf_pkg::*; #(
  parameter int NUM_AXES = NUM_AXES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  takf_in_if.sink                   in_ch,
  takf_out_if.source                out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_GAIN = 7'b0001000,
    S_DIV0 = 7'b0010000,
    S_DIV1 = 7'b0100000,
    S_WR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] dt_r, apn_r, bpn_r, mn_r;
  logic [NUM_AXES-1:0] valid_r;

  logic                     ax_r, ax_ok_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RATE_W-1:0] rate_r;
  logic signed [VAL_W-1:0]  ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic signed [VAL_W-1:0]  k0_r, k1_r, y_r;
  logic [VAL_W-1:0]         s_r;
  logic signed [39:0]       tmp_r;
  logic signed [37:0]       prod_r;
  logic [3:0]               op_r;
  logic                     ph_r;

  logic                     out_valid_r, out_axis_r;
  logic signed [VAL_W-1:0]  out_ang_r, out_bias_r;

  logic [AW-1:0]      ax_idx;
  logic [STATE_W-1:0] ram_rdata;
  logic               ram_we;
  logic               slot_free;
  logic signed [33:0] opa, opb, s_full;
  logic signed [67:0] prod_full;
  logic signed [39:0] r;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign ax_idx    = AW'(ax_r);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign ram_we    = (state_r == S_WR) && slot_free && ax_ok_r;
  assign r         = 40'(prod_r);
  assign s_full    = 34'(p00_r) + $signed({3'b0, mn_r});

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.axis_out       = out_axis_r;
  assign out_ch.filtered_angle = out_ang_r;
  assign out_ch.rate_bias      = out_bias_r;

  takf_ram #(.W(STATE_W), .D(NUM_AXES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ax_idx),
    .wdata ({ang_r, bias_r, p00_r, p01_r, p10_r, p11_r}),
    .raddr (AW'(in_ch.axis)),
    .rdata (ram_rdata)
  );

  takf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    div_req.start = ((state_r == S_GAIN) && (s_full > 34'sd0)) ||
                    ((state_r == S_DIV0) && div_rsp.done);
    div_req.num   = (state_r == S_GAIN) ? p00_r : p10_r;
    div_req.den   = (state_r == S_GAIN) ? s_full[VAL_W-1:0] : s_r;
  end

  always_comb begin
    case (op_r)
      OP_ANG_PRED: begin
        opa = $signed({3'b0, dt_r});
        opb = 34'(rate_r) - 34'(bias_r);
      end
      OP_P00_A: begin
        opa = $signed({3'b0, dt_r});
        opb = 34'(p10_r) + 34'(p01_r);
      end
      OP_P00_B: begin
        opa = $signed({3'b0, apn_r});
        opb = $signed({3'b0, dt_r});
      end
      OP_CROSS: begin
        opa = $signed({3'b0, dt_r});
        opb = 34'(p11_r);
      end
      OP_P11_PRED: begin
        opa = $signed({3'b0, bpn_r});
        opb = $signed({3'b0, dt_r});
      end
      OP_ANG_UPD: begin
        opa = 34'(k0_r);
        opb = 34'(y_r);
      end
      OP_BIAS_UPD: begin
        opa = 34'(k1_r);
        opb = 34'(y_r);
      end
      OP_P10_UPD: begin
        opa = 34'(k1_r);
        opb = 34'(p00_r);
      end
      OP_P00_UPD: begin
        opa = 34'(k0_r);
        opb = 34'(p00_r);
      end
      OP_P11_UPD: begin
        opa = 34'(k1_r);
        opb = 34'(p01_r);
      end
      OP_P01_UPD: begin
        opa = 34'(k0_r);
        opb = 34'(p01_r);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod_full = opa * opb + 68'sh2000_0000;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_LOAD;
      S_LOAD: state_nxt = ax_ok_r ? S_MUL : S_WR;
      S_MUL: begin
        if (ph_r && (op_r == OP_P11_PRED)) state_nxt = S_GAIN;
        if (ph_r && (op_r == OP_P01_UPD))  state_nxt = S_WR;
      end
      S_GAIN: state_nxt = (s_full > 34'sd0) ? S_DIV0 : S_MUL;
      S_DIV0: if (div_rsp.done) state_nxt = S_DIV1;
      S_DIV1: if (div_rsp.done) state_nxt = S_MUL;
      S_WR:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      dt_r        <= RST_TIME;
      apn_r       <= RST_ANG_NOISE;
      bpn_r       <= RST_BIAS_NOISE;
      mn_r        <= RST_MEAS_NOISE;
      op_r        <= '0;
      ph_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_TIME_STEP:  dt_r  <= clamp_reg(cfg_wdata);
          REG_ANG_NOISE:  apn_r <= clamp_reg(cfg_wdata);
          REG_BIAS_NOISE: bpn_r <= clamp_reg(cfg_wdata);
          REG_MEAS_NOISE: mn_r  <= clamp_reg(cfg_wdata);
          default: ;
        endcase
      end

      if ((state_r == S_WR) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax_r    <= in_ch.axis;
            ax_ok_r <= (32'(in_ch.axis) < NUM_AXES);
            acc_r   <= in_ch.accel_angle;
            rate_r  <= in_ch.gyro_rate;
          end
        end
        S_LOAD: begin
          if (ax_ok_r && valid_r[ax_idx]) begin
            {ang_r, bias_r, p00_r, p01_r, p10_r, p11_r} <= ram_rdata;
          end else begin
            {ang_r, bias_r, p00_r, p01_r, p10_r, p11_r} <= '0;
          end
          op_r <= OP_ANG_PRED;
          ph_r <= 1'b0;
        end
        S_MUL: begin
          ph_r <= !ph_r;
          if (!ph_r) begin
            prod_r <= prod_full[67:30];
          end else begin
            op_r <= op_r + 4'd1;
            case (op_r)
              OP_ANG_PRED: ang_r  <= sat32(40'(ang_r) + r);
              OP_P00_A:    tmp_r  <= 40'(p00_r) - r;
              OP_P00_B:    p00_r  <= sat32(tmp_r + r);
              OP_CROSS: begin
                p01_r <= sat32(40'(p01_r) - r);
                p10_r <= sat32(40'(p10_r) - r);
              end
              OP_P11_PRED: p11_r  <= sat32(40'(p11_r) + r);
              OP_ANG_UPD:  ang_r  <= sat32(40'(ang_r) + r);
              OP_BIAS_UPD: bias_r <= sat32(40'(bias_r) + r);
              OP_P10_UPD:  p10_r  <= sat32(40'(p10_r) - r);
              OP_P00_UPD:  p00_r  <= sat32(40'(p00_r) - r);
              OP_P11_UPD:  p11_r  <= sat32(40'(p11_r) - r);
              OP_P01_UPD:  p01_r  <= sat32(40'(p01_r) - r);
              default: ;
            endcase
          end
        end
        S_GAIN: begin
          y_r <= sat32(40'(acc_r) - 40'(ang_r));
          s_r <= s_full[VAL_W-1:0];
          if (!(s_full > 34'sd0)) begin
            k0_r <= '0;
            k1_r <= '0;
            op_r <= OP_ANG_UPD;
          end
        end
        S_DIV0: if (div_rsp.done) k0_r <= div_rsp.quo;
        S_DIV1: begin
          if (div_rsp.done) begin
            k1_r <= div_rsp.quo;
            op_r <= OP_ANG_UPD;
          end
        end
        S_WR: begin
          if (slot_free) begin
            out_axis_r  <= ax_r;
            out_ang_r   <= ax_ok_r ? ang_r : '0;
            out_bias_r  <= ax_ok_r ? bias_r : '0;
            if (ax_ok_r) valid_r[ax_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/takf_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// takf_chk
// Port-level checks of the tilt-angle Kalman filter.
// ----------------------------------------------------------------------------
module takf_chk import takf_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic                    out_axis,
  input wire logic signed [VAL_W-1:0] out_angle,
  input wire logic signed [VAL_W-1:0] out_bias
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_axis) && $stable(out_angle) && $stable(out_bias))
    else $error("stalled result word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second sample word taken while one is in flight");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the result slot");

endmodule

bind tilt_angle_kalman_filter takf_chk u_takf_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_axis  (out_ch.axis_out),
  .out_angle (out_ch.filtered_angle),
  .out_bias  (out_ch.rate_bias)
);
`default_nettype wire
